/* rtl/ddip_pkg.sv */
// ----------------------------------------------------------------------------
// ddip_pkg
// Types, character codes and reset constants for the delimited decimal
// integer parser.
// ----------------------------------------------------------------------------
package ddip_pkg;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Register map: the index is address bit 3 (registers 8 bytes apart).
  localparam logic REG_DELIMITER = 1'b0;
  localparam logic REG_INVALID   = 1'b1;

  // Register reset values.
  localparam logic [7:0]  DELIMITER_RESET = 8'd44;
  localparam logic [63:0] INVALID_RESET   = 64'h7FFF_FFFF_FFFF_FFFF;

  // Largest magnitude that may still take another digit (floor of 2^63 / 10).
  localparam logic [63:0] MAG_LIMIT_DIV10 = 64'd922337203685477580;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Position inside the current field.
  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_SIGN  = 5'b00010,
    PH_INT   = 5'b00100,
    PH_FRAC  = 5'b01000,
    PH_TRAIL = 5'b10000
  } phase_t;

  // One entry of the result queue.
  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* rtl/delimited_decimal_int_parser.sv */
// ----------------------------------------------------------------------------
// delimited_decimal_int_parser
// Splits a byte stream at a programmable delimiter and converts every field
// into a signed 64-bit integer.
// ----------------------------------------------------------------------------
// Usage:
// Text enters on the in_ stream, one byte per transfer; in_tlast marks the
// last byte of a string. Each finished field leaves on the out_ stream as a
// 64-bit two's complement value, with out_tlast set on the final field of
// the string. A delimiter byte ends a field; a delimiter that is also the
// last byte yields two results, the field it ends and an empty field.
// Fields that are empty, malformed or out of range carry invalid_value.
// The APB port holds the delimiter (address 0) and invalid_value
// (address 8); write them only while the block is idle.
// A result is presented on out_ once its completing byte has passed the
// input register and been written to the result queue. Throughput: one byte
// per cycle while the queue has room, set by the digit accumulate
// (shift-add by ten) on the field state.
// Accepted bytes pass one input register and then a four-entry result
// queue; in_tready drops while a byte waits in the input register and the
// queue has fewer than two free entries, so a stalled receiver backs up
// into the input stream without loss.
// Reset (synchronous, rst_n low) empties the pipeline and queue, clears the
// field state and restores delimiter to a comma and invalid_value to 2^63-1.
// ----------------------------------------------------------------------------
module delimited_decimal_int_parser
  import ddip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] field_value
  output logic        out_tlast,  // last_field
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Only address bit 3 is decoded, so the two
  // registers alias across the low address bits.
  // --------------------------------------------------------------------------
  logic [7:0]  delim_r;
  logic [63:0] inval_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == REG_INVALID) ? inval_r : {56'd0, delim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIMITER_RESET;
      inval_r <= INVALID_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[3] == REG_DELIMITER) begin
        delim_r <= cfg_pwdata[7:0];
      end else begin
        inval_r <= cfg_pwdata;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input register. A byte waits here until the result queue can take the
  // up to two results it may cause.
  // --------------------------------------------------------------------------
  logic            stg_vld_r;
  logic [7:0]      stg_byte_r;
  logic            stg_last_r;
  logic [CNT_W-1:0] cnt_r;
  logic            room;
  logic            in_fire;
  logic            stg_fire;

  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_tready = !stg_vld_r || room;
  assign in_fire   = in_tvalid && in_tready;
  assign stg_fire  = stg_vld_r && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_fire) begin
      stg_vld_r <= 1'b1;
    end else if (stg_fire) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Field state and the per-byte update.
  // --------------------------------------------------------------------------
  logic [63:0] mag_r;
  logic        neg_r;
  phase_t      ph_r;
  logic        seen_r;
  logic        bad_r;

  logic [63:0] t_mag;
  logic        t_neg;
  phase_t      t_ph;
  logic        t_seen;
  logic        t_bad;

  logic        is_delim;
  logic        is_sign;
  logic        is_digit;
  logic [63:0] digit;
  logic [63:0] mag_x10;
  logic        mag_ovf;

  assign is_delim = (stg_byte_r == delim_r);
  assign is_sign  = (stg_byte_r == CH_PLUS) || (stg_byte_r == CH_MINUS);
  assign is_digit = (stg_byte_r >= CH_ZERO) && (stg_byte_r <= CH_NINE);
  assign digit    = {60'd0, stg_byte_r[3:0]};
  // Multiply by ten as (m << 3) + (m << 1); the sum is only taken when it
  // cannot wrap, since the overflow check stops any magnitude above 2^63.
  assign mag_x10  = {mag_r[60:0], 3'b000} + {mag_r[62:0], 1'b0} + digit;
  assign mag_ovf  = (mag_r > MAG_LIMIT_DIV10) ||
                    ((mag_r == MAG_LIMIT_DIV10) && (stg_byte_r[3:0] > 4'd8));

  // Field state after taking a non-delimiter byte. A bad field ignores
  // everything until it is emitted.
  always_comb begin
    t_mag  = mag_r;
    t_neg  = neg_r;
    t_ph   = ph_r;
    t_seen = seen_r;
    t_bad  = bad_r;
    if (!bad_r) begin
      if (is_space(stg_byte_r)) begin
        if (ph_r == PH_SIGN) begin
          t_bad = 1'b1;
        end else if ((ph_r == PH_INT) || (ph_r == PH_FRAC)) begin
          t_ph = PH_TRAIL;
        end
      end else if (is_sign) begin
        if (ph_r == PH_LEAD) begin
          t_ph  = PH_SIGN;
          t_neg = (stg_byte_r == CH_MINUS);
        end else begin
          t_bad = 1'b1;
        end
      end else if (is_digit) begin
        if (ph_r == PH_TRAIL) begin
          t_bad = 1'b1;
        end else if (ph_r == PH_FRAC) begin
          // Fraction digits only count as digits; truncation drops them.
          t_seen = 1'b1;
        end else begin
          t_ph   = PH_INT;
          t_seen = 1'b1;
          if (mag_ovf) begin
            t_bad = 1'b1;
          end else begin
            t_mag = mag_x10;
          end
        end
      end else if (stg_byte_r == CH_DOT) begin
        if ((ph_r == PH_LEAD) || (ph_r == PH_SIGN) || (ph_r == PH_INT)) begin
          t_ph = PH_FRAC;
        end else begin
          t_bad = 1'b1;
        end
      end else begin
        t_bad = 1'b1;
      end
    end
  end

  // The field that is emitted: the stored one when a delimiter ends it,
  // else the one that includes the current byte.
  logic [63:0] src_mag;
  logic        src_neg;
  logic        src_invalid;
  logic [63:0] field_val;
  logic        emit1;
  logic        emit2;

  assign src_mag     = is_delim ? mag_r : t_mag;
  assign src_neg     = is_delim ? neg_r : t_neg;
  // A positive magnitude of 2^63 is out of range; negative 2^63 is fine.
  assign src_invalid = (is_delim ? (bad_r || !seen_r) : (t_bad || !t_seen)) ||
                       (!src_neg && src_mag[63]);
  assign field_val   = src_invalid ? inval_r :
                       (src_neg ? (64'd0 - src_mag) : src_mag);
  assign emit1       = stg_fire && (is_delim || stg_last_r);
  assign emit2       = stg_fire && is_delim && stg_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r  <= 64'd0;
      neg_r  <= 1'b0;
      ph_r   <= PH_LEAD;
      seen_r <= 1'b0;
      bad_r  <= 1'b0;
    end else if (stg_fire) begin
      if (emit1) begin
        mag_r  <= 64'd0;
        neg_r  <= 1'b0;
        ph_r   <= PH_LEAD;
        seen_r <= 1'b0;
        bad_r  <= 1'b0;
      end else begin
        mag_r  <= t_mag;
        neg_r  <= t_neg;
        ph_r   <= t_ph;
        seen_r <= t_seen;
        bad_r  <= t_bad;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue. Up to two entries are written per cycle; the second one
  // is always the empty field that follows a trailing delimiter.
  // --------------------------------------------------------------------------
  result_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic                 out_fire;

  assign out_fire   = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = fifo_r[rd_ptr_r].value;
  assign out_tlast  = fifo_r[rd_ptr_r].last;
  assign cnt_nxt    = cnt_r + CNT_W'(emit1) + CNT_W'(emit2) - CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (emit1) begin
      fifo_r[wr_ptr_r] <= '{value: field_val, last: !is_delim};
    end
    if (emit2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= '{value: inval_r, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(emit1) + FIFO_AW'(emit2);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(out_fire);
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // The queue never holds more entries than it has.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count exceeds depth");

  // Emitting a field leaves a cleared field behind.
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit1 |=> (mag_r == 64'd0) && !seen_r && !bad_r && !neg_r && (ph_r == PH_LEAD))
    else $error("field state not cleared after emit");

  // A bad field stays bad until it is emitted.
  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (bad_r && !emit1) |=> bad_r)
    else $error("bad flag dropped inside a field");

  // The magnitude only grows through digits.
  a_mag_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (mag_r == 64'd0))
    else $error("nonzero magnitude without a digit");
`endif

endmodule
